/* design/tdf_pkg.sv */
// shared types, constants and the control store of the trial-division factoriser
// depends on nothing; imported by trial_division_factorizer

package tdf_pkg;

    localparam int VAL_W  = 32;                // width of the number and of a factor
    localparam int DIV_W  = VAL_W / 2 + 1;     // trial divisor never passes sqrt + 1
    localparam int SQ_W   = 2 * DIV_W;         // square of the divisor
    localparam int POS_W  = 5;                 // position of a factor in the list
    localparam int CNT_W  = 6;                 // factors found so far
    localparam int DCNT_W = $clog2(VAL_W);     // divider step count
    localparam int PC_W   = 4;                 // step counter

    typedef logic [PC_W-1:0] pc_t;

    // step addresses of the program
    localparam pc_t S_IDLE    = 4'd0;
    localparam pc_t S_CHK     = 4'd1;
    localparam pc_t S_SQ      = 4'd2;
    localparam pc_t S_LOOP    = 4'd3;
    localparam pc_t S_CMPSQ   = 4'd4;
    localparam pc_t S_DIVINIT = 4'd5;
    localparam pc_t S_DIVSTEP = 4'd6;
    localparam pc_t S_TEST    = 4'd7;
    localparam pc_t S_EMITDIV = 4'd8;
    localparam pc_t S_INC     = 4'd9;
    localparam pc_t S_PRIME   = 4'd10;
    localparam pc_t S_DONE    = 4'd11;
    localparam pc_t S_EMPTY   = 4'd12;

    // datapath operation of one step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQUARE,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_EMITDIV,
        OP_INC,
        OP_EMITREM,
        OP_FLUSH,
        OP_EMPTY
    } op_t;

    // jump condition of one step: jump to target when it holds, else fall through
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NSTART,
        C_LT2,
        C_LE1,
        C_SQGT,
        C_DIVBUSY,
        C_NZREM
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // control store
    function automatic ctrl_t ucode_rom(input pc_t addr);
        ctrl_t cw;
        case (addr)
            S_IDLE:    cw = '{op: OP_LOAD,    cond: C_NSTART,  target: S_IDLE};
            S_CHK:     cw = '{op: OP_NOP,     cond: C_LT2,     target: S_EMPTY};
            S_SQ:      cw = '{op: OP_SQUARE,  cond: C_NEXT,    target: S_IDLE};
            S_LOOP:    cw = '{op: OP_NOP,     cond: C_LE1,     target: S_DONE};
            S_CMPSQ:   cw = '{op: OP_NOP,     cond: C_SQGT,    target: S_PRIME};
            S_DIVINIT: cw = '{op: OP_DIVINIT, cond: C_NEXT,    target: S_IDLE};
            S_DIVSTEP: cw = '{op: OP_DIVSTEP, cond: C_DIVBUSY, target: S_DIVSTEP};
            S_TEST:    cw = '{op: OP_NOP,     cond: C_NZREM,   target: S_INC};
            S_EMITDIV: cw = '{op: OP_EMITDIV, cond: C_ALWAYS,  target: S_LOOP};
            S_INC:     cw = '{op: OP_INC,     cond: C_ALWAYS,  target: S_SQ};
            S_PRIME:   cw = '{op: OP_EMITREM, cond: C_ALWAYS,  target: S_DONE};
            S_DONE:    cw = '{op: OP_FLUSH,   cond: C_ALWAYS,  target: S_IDLE};
            S_EMPTY:   cw = '{op: OP_EMPTY,   cond: C_ALWAYS,  target: S_IDLE};
            default:   cw = '{op: OP_NOP,     cond: C_ALWAYS,  target: S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

/* design/trial_division_factorizer.sv */
// trial-division prime factoriser: microcoded sequencer with a bit-serial divider
// depends on tdf_pkg (control store, step addresses, widths)

// usage
//   an item is taken at a rising edge with start high and busy low; value is the
//   number to split. busy stays high until the whole list has been sent
//   results leave on factor, position, last and empty_res, each valid for one
//   cycle while strobe is high; the receiver cannot stall, so every result must
//   be taken in the cycle it is shown
//   factors come in ascending order with repeats, numbered from 0; the final
//   one has last set. values 0 and 1 give a single result with factor 0,
//   empty_res and last set
//   a found factor is held back one step so that last can be set on it, hence
//   a result is shown when the next factor is found or the list ends
//   search: each trial divisor goes through square, two compares, a 32-step
//   restoring division, test and increment; only 2 and then odd divisors are
//   tried, and the search stops once divisor squared exceeds the remainder.
//   the serial divider sets the pace of the search
//   reset clears the step counter, the strobe, the factor count and the valid
//   flag of the held-back factor; the block is ready in the first cycle after reset

module trial_division_factorizer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [31:0]               value,
    output logic                      strobe,
    output logic [31:0]               factor,
    output logic [tdf_pkg::POS_W-1:0] position,
    output logic                      last,
    output logic                      empty_res
);
    import tdf_pkg::*;

    // sequencer
    pc_t   pc_reg, pc_next;
    ctrl_t cw;

    // datapath registers
    logic [VAL_W-1:0]  rem_reg, rem_next;       // part not yet factored
    logic [DIV_W-1:0]  div_reg, div_next;       // trial divisor
    logic [SQ_W-1:0]   sq_reg, sq_next;         // divisor squared
    logic [VAL_W-1:0]  quo_reg, quo_next;       // dividend shifting out, quotient in
    logic [DIV_W-1:0]  prem_reg, prem_next;     // partial remainder of the division
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;     // division step count
    logic [CNT_W-1:0]  cnt_reg, cnt_next;       // factors found
    logic [VAL_W-1:0]  pend_reg, pend_next;     // held-back factor
    logic [POS_W-1:0]  ppos_reg, ppos_next;
    logic              pval_reg, pval_next;

    // result registers
    logic              strobe_reg, strobe_next;
    logic [31:0]       factor_reg, factor_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              last_reg, last_next;
    logic              empty_reg, empty_next;

    // condition flags
    logic div_last;
    logic sq_gt;
    logic rem_lt2;
    logic rem_le1;

    // divider step
    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           qbit;

    assign cw       = ucode_rom(pc_reg);
    assign div_last = (dcnt_reg == DCNT_W'(VAL_W - 1));
    assign sq_gt    = (sq_reg > SQ_W'(rem_reg));
    assign rem_lt2  = (rem_reg < VAL_W'(2));
    assign rem_le1  = (rem_reg <= VAL_W'(1));

    assign shifted = {prem_reg, quo_reg[VAL_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign qbit    = (shifted >= {1'b0, div_reg});

    // next step
    always_comb
    begin
        case (cw.cond)
            C_NEXT:    pc_next = pc_reg + pc_t'(1);
            C_ALWAYS:  pc_next = cw.target;
            C_NSTART:  pc_next = start ? pc_reg + pc_t'(1) : cw.target;
            C_LT2:     pc_next = rem_lt2 ? cw.target : pc_reg + pc_t'(1);
            C_LE1:     pc_next = rem_le1 ? cw.target : pc_reg + pc_t'(1);
            C_SQGT:    pc_next = sq_gt ? cw.target : pc_reg + pc_t'(1);
            C_DIVBUSY: pc_next = div_last ? pc_reg + pc_t'(1) : cw.target;
            C_NZREM:   pc_next = (prem_reg != '0) ? cw.target : pc_reg + pc_t'(1);
            default:   pc_next = S_IDLE;
        endcase
    end

    // datapath controlled by the current control word
    always_comb
    begin
        rem_next    = rem_reg;
        div_next    = div_reg;
        sq_next     = sq_reg;
        quo_next    = quo_reg;
        prem_next   = prem_reg;
        dcnt_next   = dcnt_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        ppos_next   = ppos_reg;
        pval_next   = pval_reg;
        strobe_next = 1'b0;
        factor_next = factor_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;
        empty_next  = empty_reg;

        case (cw.op)
            OP_LOAD:
            begin
                if (start)
                begin
                    rem_next  = value[VAL_W-1:0];
                    div_next  = DIV_W'(2);
                    cnt_next  = '0;
                    pval_next = 1'b0;
                end
            end
            OP_SQUARE:
            begin
                sq_next = div_reg * div_reg;
            end
            OP_DIVINIT:
            begin
                quo_next  = rem_reg;
                prem_next = '0;
                dcnt_next = '0;
            end
            OP_DIVSTEP:
            begin
                prem_next = qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
                quo_next  = {quo_reg[VAL_W-2:0], qbit};
                dcnt_next = dcnt_reg + DCNT_W'(1);
            end
            OP_EMITDIV, OP_EMITREM:
            begin
                // show the held-back factor, if any, then hold back the new one
                if (pval_reg)
                begin
                    strobe_next = 1'b1;
                    factor_next = pend_reg;
                    pos_next    = ppos_reg;
                    last_next   = 1'b0;
                    empty_next  = 1'b0;
                end
                pval_next = 1'b1;
                ppos_next = cnt_reg[POS_W-1:0];
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cw.op == OP_EMITDIV)
                begin
                    pend_next = VAL_W'(div_reg);
                    rem_next  = quo_reg;
                end
                else
                begin
                    pend_next = rem_reg;
                    rem_next  = VAL_W'(1);
                end
            end
            OP_INC:
            begin
                // after 2 only odd divisors can divide
                div_next = div_reg + ((div_reg == DIV_W'(2)) ? DIV_W'(1) : DIV_W'(2));
            end
            OP_FLUSH:
            begin
                strobe_next = 1'b1;
                factor_next = pend_reg;
                pos_next    = ppos_reg;
                last_next   = 1'b1;
                empty_next  = 1'b0;
                pval_next   = 1'b0;
            end
            OP_EMPTY:
            begin
                strobe_next = 1'b1;
                factor_next = '0;
                pos_next    = '0;
                last_next   = 1'b1;
                empty_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= S_IDLE;
            strobe_reg <= 1'b0;
            pval_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            pc_reg     <= pc_next;
            strobe_reg <= strobe_next;
            pval_reg   <= pval_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        sq_reg     <= sq_next;
        quo_reg    <= quo_next;
        prem_reg   <= prem_next;
        dcnt_reg   <= dcnt_next;
        pend_reg   <= pend_next;
        ppos_reg   <= ppos_next;
        factor_reg <= factor_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        empty_reg  <= empty_next;
    end

    // outputs
    always_comb
    begin
        busy      = (pc_reg != S_IDLE);
        strobe    = strobe_reg;
        factor    = factor_reg;
        position  = pos_reg;
        last      = last_reg;
        empty_res = empty_reg;
    end

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an item was taken");

    a_end_has_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && last))
        else $error("list ended without a final result");

    a_notlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("non-final result shown while idle");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && empty_res) |-> (last && factor == '0))
        else $error("empty result malformed");

    a_factor_ge2: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !empty_res) |-> (factor >= 32'd2))
        else $error("factor below two");

endmodule
